// ===== rtl/lcabl_pkg.sv =====
// ----------------------------------------------------------------------------
// lcabl_pkg
// Shared widths, codes and types of the lowest common ancestor unit.
// ----------------------------------------------------------------------------
package lcabl_pkg;

   localparam int NODE_W  = 10;
   localparam int DEPTH_W = 10;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   // Request data: node_a, node_b. Response data: ancestor.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam int unsigned NODES_DEFAULT  = 1024;
   localparam int unsigned LEVELS_DEFAULT = 10;

   typedef enum logic {
      FUNC_ATTACH = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE_Q,
      S_REDUCE_R,
      S_ATT_START,
      S_ATT_ROOT,
      S_ATT_DEPTH,
      S_ATT_LEVEL,
      S_Q_DEPTH_X,
      S_Q_DEPTH_Y,
      S_Q_ORDER,
      S_Q_LIFT,
      S_Q_LIFT_WAIT,
      S_Q_COMPARE,
      S_Q_READ_Y,
      S_Q_DECIDE,
      S_Q_FINAL
   } state_type;

endpackage

// ===== rtl/lcabl_ram.sv =====
// ----------------------------------------------------------------------------
// lcabl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lcabl_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/lca_binary_lifting_unit.sv =====
// ----------------------------------------------------------------------------
// lca_binary_lifting_unit
// Lowest common ancestor of a rooted tree by binary lifting.
//
// Items arrive on the req_ stream: tuser selects attach (0) or query (1),
// tdata carries node_a and node_b. An attach enters node_a under parent
// node_b (equal nodes make node_a a root); nodes are attached parent first.
// Attaches produce no response. A query returns one item on the rsp_ stream
// holding the lowest common ancestor of node_a and node_b.
// One item is worked on at a time; req_tready is high only while idle.
// Every item first folds the node numbers into the table, quotient then remainder.
// An attach then writes the node's depth and its ancestor at every level,
// paced by the single write port of the ancestor table.
// A query reads both depths, lifts the deeper node by their difference and
// then, unless the nodes meet there, lifts both nodes jointly level by level;
// it is bound by the table's one read port, two reads per level in the joint
// lift.
// The response sits in an output register: a stalled receiver holds it there
// while the next item is already accepted. Reset clears control state only;
// both tables are undefined until written.
// ----------------------------------------------------------------------------
module lca_binary_lifting_unit #(
   parameter int unsigned NODES  = lcabl_pkg::NODES_DEFAULT,
   parameter int unsigned LEVELS = lcabl_pkg::LEVELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] node_a, [19:10] node_b, [23:20] zero
   input  logic [lcabl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] func
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] ancestor, [15:10] zero
   output logic [lcabl_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import lcabl_pkg::*;

   localparam int NW       = $clog2(NODES);
   localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DIFF_W   = 1 << LW;
   localparam int JT_DEPTH = NODES << LW;
   localparam int RS       = NODE_W + NW;
   localparam int MW       = RS + 1;
   localparam int PW       = NODE_W + MW;

   // Reciprocal for the node fold: floor(v * RECIP / 2^RS) == floor(v / NODES).
   localparam longint RECIP_L = ((longint'(1) << RS) + longint'(NODES) - 1) / longint'(NODES);
   localparam logic [MW-1:0] RECIP    = MW'(RECIP_L);
   localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

   state_type            state_ff, state_in;
   func_type             func_ff, func_in;
   logic [NODE_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [NODE_W-1:0]    qa_ff, qa_in, qb_ff, qb_in;
   logic [NW-1:0]        x_ff, x_in, y_ff, y_in;
   logic [NW-1:0]        ax_ff, ax_in, res_ff, res_in;
   logic [LW-1:0]        lvl_ff, lvl_in;
   logic [DEPTH_W-1:0]   dx_ff, dx_in;
   logic [DIFF_W-1:0]    diff_ff, diff_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [PW-1:0]        prod_a, prod_b;
   logic [31:0]          back_a, back_b;
   logic [NODE_W-1:0]    rem_a, rem_b;

   logic                 jt_we;
   logic [NW+LW-1:0]     jt_waddr, jt_raddr;
   logic [NW-1:0]        jt_wdata, jt_rdata;
   logic                 ds_we;
   logic [NW-1:0]        ds_waddr, ds_raddr;
   logic [DEPTH_W-1:0]   ds_wdata, ds_rdata;

   logic [NW-1:0]        nx, ny;
   logic [LW-1:0]        next_lvl;
   logic [NW-1:0]        att_node;

   lcabl_ram #(
      .WIDTH (NW),
      .DEPTH (JT_DEPTH)
   ) u_jump_ram (
      .clock   (clock),
      .wr_en   (jt_we),
      .wr_addr (jt_waddr),
      .wr_data (jt_wdata),
      .rd_addr (jt_raddr),
      .rd_data (jt_rdata)
   );

   lcabl_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (NODES)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (ds_we),
      .wr_addr (ds_waddr),
      .wr_data (ds_wdata),
      .rd_addr (ds_raddr),
      .rd_data (ds_rdata)
   );

   // Node fold modulo NODES: quotient by reciprocal, then remainder.
   assign prod_a = PW'(a_ff) * PW'(RECIP);
   assign prod_b = PW'(b_ff) * PW'(RECIP);
   assign back_a = 32'(qa_ff) * 32'(NODES);
   assign back_b = 32'(qb_ff) * 32'(NODES);
   assign rem_a  = a_ff - NODE_W'(back_a);
   assign rem_b  = b_ff - NODE_W'(back_b);

   // Joint lift: both nodes move up only where their ancestors differ.
   assign nx       = (ax_ff != jt_rdata) ? ax_ff : x_ff;
   assign ny       = (ax_ff != jt_rdata) ? jt_rdata : y_ff;
   assign next_lvl = (lvl_ff == '0) ? '0 : lvl_ff - 1'b1;

   // When the attach walk lands on the node itself, the read of that entry
   // raced its own write; the node is then its own ancestor at every level
   // above.
   assign att_node = (ax_ff == x_ff) ? x_ff : jt_rdata;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ax_ff       <= ax_in;
      res_ff      <= res_in;
      lvl_ff      <= lvl_in;
      dx_ff       <= dx_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ax_in        = ax_ff;
      res_in       = res_ff;
      lvl_in       = lvl_ff;
      dx_in        = dx_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      jt_we    = 1'b0;
      jt_waddr = {x_ff, lvl_ff};
      jt_wdata = x_ff;
      jt_raddr = {x_ff, lvl_ff};
      ds_we    = 1'b0;
      ds_waddr = x_ff;
      ds_wdata = '0;
      ds_raddr = x_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = func_type'(req_tuser);
               a_in     = req_tdata[NODE_W-1:0];
               b_in     = req_tdata[2*NODE_W-1:NODE_W];
               state_in = S_REDUCE_Q;
            end
         end
         S_REDUCE_Q: begin
            qa_in    = NODE_W'(prod_a >> RS);
            qb_in    = NODE_W'(prod_b >> RS);
            state_in = S_REDUCE_R;
         end
         S_REDUCE_R: begin
            x_in     = NW'(rem_a);
            y_in     = NW'(rem_b);
            state_in = (func_ff == FUNC_ATTACH) ? S_ATT_START : S_Q_DEPTH_X;
         end
         S_ATT_START: begin
            if (x_ff == y_ff) begin
               // A root is its own ancestor at every level.
               ds_we    = 1'b1;
               jt_we    = 1'b1;
               jt_waddr = {x_ff, LW'(0)};
               lvl_in   = LW'(1);
               state_in = (LEVELS == 1) ? S_IDLE : S_ATT_ROOT;
            end else begin
               ds_raddr = y_ff;
               state_in = S_ATT_DEPTH;
            end
         end
         S_ATT_ROOT: begin
            jt_we    = 1'b1;
            lvl_in   = lvl_ff + 1'b1;
            state_in = (lvl_ff == LAST_LVL) ? S_IDLE : S_ATT_ROOT;
         end
         S_ATT_DEPTH: begin
            ds_we    = 1'b1;
            ds_wdata = (ds_rdata == DEPTH_MAX) ? DEPTH_MAX : ds_rdata + 1'b1;
            jt_we    = 1'b1;
            jt_waddr = {x_ff, LW'(0)};
            jt_wdata = y_ff;
            jt_raddr = {y_ff, LW'(0)};
            ax_in    = y_ff;
            lvl_in   = LW'(1);
            state_in = (LEVELS == 1) ? S_IDLE : S_ATT_LEVEL;
         end
         S_ATT_LEVEL: begin
            // The level below was just read; it doubles into this level and
            // names the node whose entry at this level is read next.
            jt_we    = 1'b1;
            jt_wdata = att_node;
            jt_raddr = {att_node, lvl_ff};
            ax_in    = att_node;
            lvl_in   = lvl_ff + 1'b1;
            state_in = (lvl_ff == LAST_LVL) ? S_IDLE : S_ATT_LEVEL;
         end
         S_Q_DEPTH_X: begin
            ds_raddr = x_ff;
            state_in = S_Q_DEPTH_Y;
         end
         S_Q_DEPTH_Y: begin
            ds_raddr = y_ff;
            dx_in    = ds_rdata;
            state_in = S_Q_ORDER;
         end
         S_Q_ORDER: begin
            // Keep the deeper node in x.
            if (dx_ff < ds_rdata) begin
               x_in    = y_ff;
               y_in    = x_ff;
               diff_in = DIFF_W'(ds_rdata - dx_ff);
            end else begin
               diff_in = DIFF_W'(dx_ff - ds_rdata);
            end
            lvl_in   = LAST_LVL;
            state_in = S_Q_LIFT;
         end
         S_Q_LIFT: begin
            if (diff_ff[lvl_ff]) begin
               jt_raddr = {x_ff, lvl_ff};
               state_in = S_Q_LIFT_WAIT;
            end else begin
               lvl_in   = next_lvl;
               state_in = (lvl_ff == '0) ? S_Q_COMPARE : S_Q_LIFT;
            end
         end
         S_Q_LIFT_WAIT: begin
            x_in     = jt_rdata;
            lvl_in   = next_lvl;
            state_in = (lvl_ff == '0) ? S_Q_COMPARE : S_Q_LIFT;
         end
         S_Q_COMPARE: begin
            if (x_ff == y_ff) begin
               res_in   = x_ff;
               state_in = S_Q_FINAL;
            end else begin
               jt_raddr = {x_ff, LAST_LVL};
               lvl_in   = LAST_LVL;
               state_in = S_Q_READ_Y;
            end
         end
         S_Q_READ_Y: begin
            ax_in    = jt_rdata;
            jt_raddr = {y_ff, lvl_ff};
            state_in = S_Q_DECIDE;
         end
         S_Q_DECIDE: begin
            x_in     = nx;
            y_in     = ny;
            // After level zero this read fetches the parent, the answer.
            jt_raddr = {nx, next_lvl};
            lvl_in   = next_lvl;
            if (lvl_ff == '0) begin
               res_in   = '0;
               state_in = S_Q_FINAL;
            end else begin
               state_in = S_Q_READ_Y;
            end
         end
         S_Q_FINAL: begin
            // A compare hit leaves the answer in res_ff; the joint lift
            // leaves it on the table's read data.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (x_ff == y_ff) ? NODE_W'(res_ff) : NODE_W'(jt_rdata);
               state_in     = S_IDLE;
            end else begin
               jt_raddr = {x_ff, LW'(0)};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/lcabl_checker.sv =====
// ----------------------------------------------------------------------------
// lcabl_checker
// Port-level checks of the lowest common ancestor unit, bound to its top.
// ----------------------------------------------------------------------------
module lcabl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [lcabl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lcabl_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import lcabl_pkg::*;

   logic req_fire;

   assign req_fire = req_tvalid && req_tready && (req_tdata != '1 || req_tuser != 1'b0
                     || req_tuser == 1'b0);

   // A stalled response stays offered.
   rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its data.
   rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // One item at a time: the unit is busy right after taking one.
   busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second item accepted while busy");

   // A new response appears only as the unit returns to idle.
   rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("response raised while still working");

   // No response can follow an item in the very next cycle.
   no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !$rose(rsp_tvalid))
      else $error("response raised right after an item");

endmodule

bind lca_binary_lifting_unit lcabl_checker u_lcabl_checker (.*);
